// ----- design/pvoa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package pvoa_pkg;

    localparam int VALUE_W          = 13;
    localparam int BEARING_W        = 16;
    localparam int ALPHA_W          = 15;
    localparam int DELTA_W          = 13;
    localparam int SPEED_W          = 16;
    localparam int COUNT_W          = 6;
    localparam int ACC_W            = 19;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 16;
    localparam int DP_W             = 36;
    localparam int Z_W              = 34;
    localparam int SQ_W             = 38;
    localparam int ANG_W            = 17;
    localparam int GAIN_Q16         = 39797;
    localparam int DEF_MAX_READINGS = 24;
    localparam int DEF_CORDIC_STEPS = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_RST = 15'd1820;
    localparam logic [DELTA_W-1:0] DELTA_RST = 13'd2048;
    localparam logic [SPEED_W-1:0] SPEED_RST = 16'd640;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA = 2'd0,
        CFG_DELTA = 2'd1,
        CFG_SPEED = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_STRAIGHT = 2'd0,
        MODE_LEFT     = 2'd1,
        MODE_RIGHT    = 2'd2
    } t_mode;

    // bearing folded into [-pi/2, pi/2]; flip negates the magnitude
    typedef struct packed {
        logic [VALUE_W-1:0]          value;
        logic signed [BEARING_W-1:0] bearing;
        logic                        flip;
        logic                        last;
    } t_item;

    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41721;
            5'd15: v = 32'd20860;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2607;
            5'd19: v = 32'd1303;
            5'd20: v = 32'd651;
            5'd21: v = 32'd325;
            5'd22: v = 32'd162;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- design/pvoa_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pvoa_front (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic [pvoa_pkg::VALUE_W-1:0]         i_reading_value,
    input  wire logic signed [pvoa_pkg::BEARING_W-1:0] i_reading_bearing,
    input  wire logic                                 i_last_reading,
    output logic                                      o_q_valid,
    output pvoa_pkg::t_item                           o_q_item,
    input  wire logic                                 i_q_pop
);
    import pvoa_pkg::*;

    t_item      r_mem [2];
    logic [1:0] r_cnt;
    logic       r_wr;
    logic       r_rd;
    t_item      n_item;
    logic       push;
    logic       pop;

    // fold bearing outside [-pi/2, pi/2] by pi
    always_comb begin
        n_item.value = i_reading_value;
        n_item.last  = i_last_reading;
        if (i_reading_bearing > 16'sd16384) begin
            n_item.bearing = i_reading_bearing - 16'sh8000;
            n_item.flip    = 1'b1;
        end else if (i_reading_bearing < -16'sd16384) begin
            n_item.bearing = i_reading_bearing + 16'sh8000;
            n_item.flip    = 1'b1;
        end else begin
            n_item.bearing = i_reading_bearing;
            n_item.flip    = 1'b0;
        end
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_cnt != 2'd0) else $error("pop from empty queue");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_cnt == $past(r_cnt) + 2'd1) else $error("queue count lost");
`endif
endmodule
`default_nettype wire

// ----- design/pvoa_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pvoa_back #(
    parameter int MAX_READINGS = pvoa_pkg::DEF_MAX_READINGS,
    parameter int CORDIC_STEPS = pvoa_pkg::DEF_CORDIC_STEPS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [pvoa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [pvoa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_q_valid,
    input  wire pvoa_pkg::t_item                     i_q_item,
    output logic                                     o_q_pop,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [pvoa_pkg::SPEED_W-1:0]             o_left_speed,
    output logic [pvoa_pkg::SPEED_W-1:0]             o_right_speed,
    output logic [1:0]                               o_led_quadrant,
    output logic [1:0]                               o_drive_mode
);
    import pvoa_pkg::*;

    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam logic [STEP_W-1:0]  LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
    localparam logic [COUNT_W-1:0] MAX_CNT   = COUNT_W'(MAX_READINGS);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_ROT  = 8'b0000_0100,
        S_ACC  = 8'b0000_1000,
        S_SQ   = 8'b0001_0000,
        S_LIM  = 8'b0010_0000,
        S_VEC  = 8'b0100_0000,
        S_DEC  = 8'b1000_0000
    } t_state;

    t_state                     r_state, n_state;
    logic [ALPHA_W-1:0]         r_alpha;
    logic [DELTA_W-1:0]         r_delta;
    logic [SPEED_W-1:0]         r_speed;
    t_item                      r_item;
    logic signed [DP_W-1:0]     r_x, r_y, n_x, n_y;
    logic signed [Z_W-1:0]      r_z, n_z;
    logic [STEP_W-1:0]          r_step;
    logic signed [ACC_W-1:0]    r_sx, r_sy;
    logic [COUNT_W-1:0]         r_count;
    logic signed [SQ_W-1:0]     r_sqx, r_sqy;
    logic [DELTA_W+COUNT_W-1:0] r_dc;
    logic [SQ_W-1:0]            r_len2, r_lim;
    logic signed [ANG_W-1:0]    r_ang;
    logic                       r_spec;

    logic signed [DP_W-1:0]     dx, dy;
    logic signed [Z_W-1:0]      atan_z;
    logic                       pos;
    logic [VALUE_W+15:0]        prod;
    logic signed [DP_W-1:0]     cx_full;
    logic signed [DP_W-1:0]     cy_full;
    logic signed [ACC_W+1:0]    nsx, nsy;
    logic [31:0]                zr;
    logic signed [ANG_W-1:0]    vec_ang, ang;
    logic signed [ANG_W-1:0]    alpha_s;
    logic                       straight;
    logic                       out_free;
    logic signed [DP_W-1:0]     vx0, vy0;

    assign out_free = !o_valid || !i_stall;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;

    // shared CORDIC micro-rotation
    always_comb begin
        dx     = r_y >>> r_step;
        dy     = r_x >>> r_step;
        atan_z = Z_W'({2'b00, atan_entry(5'(r_step))});
        pos    = (r_state == S_ROT) ? !r_z[Z_W-1] : !(r_y > 0);
        if (pos) begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - atan_z;
        end else begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + atan_z;
        end
    end

    function automatic logic signed [ACC_W-1:0] sat(input logic signed [ACC_W+1:0] v);
        logic signed [ACC_W-1:0] s;
        if (v > (ACC_W+2)'(262143)) begin
            s = ACC_W'(262143);
        end else if (v < -(ACC_W+2)'(262144)) begin
            s = -ACC_W'(262144);
        end else begin
            s = v[ACC_W-1:0];
        end
        return s;
    endfunction

    always_comb begin
        prod    = (VALUE_W+16)'(r_item.value) * (VALUE_W+16)'(GAIN_Q16);
        cx_full = (r_x + DP_W'(32768)) >>> 16;
        cy_full = (r_y + DP_W'(32768)) >>> 16;
        nsx     = (ACC_W+2)'(r_sx) + (ACC_W+2)'(cx_full);
        nsy     = (ACC_W+2)'(r_sy) + (ACC_W+2)'(cy_full);
        vx0     = DP_W'(r_sx) <<< 12;
        vy0     = DP_W'(r_sy) <<< 12;
        zr      = r_z[31:0] + 32'h0000_8000;
        vec_ang = ANG_W'($signed(zr[31:16]));
        if (zr[31:16] == 16'h8000 && r_sy > 0) begin
            vec_ang = ANG_W'(32768);
        end
        ang      = r_spec ? r_ang : vec_ang;
        alpha_s  = $signed({2'b00, r_alpha});
        straight = (ang >= -alpha_s) && (ang <= alpha_s) && (r_len2 < r_lim);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = (r_count < MAX_CNT) ? S_MUL : (i_q_item.last ? S_SQ : S_IDLE);
                end
            end
            S_MUL: n_state = S_ROT;
            S_ROT: if (r_step == LAST_STEP) begin
                n_state = S_ACC;
            end
            S_ACC: n_state = r_item.last ? S_SQ : S_IDLE;
            S_SQ:  n_state = S_LIM;
            S_LIM: n_state = r_spec ? S_DEC : S_VEC;
            S_VEC: if (r_step == LAST_STEP) begin
                n_state = S_DEC;
            end
            S_DEC: if (out_free) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_alpha <= ALPHA_RST;
            r_delta <= DELTA_RST;
            r_speed <= SPEED_RST;
            r_sx    <= '0;
            r_sy    <= '0;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ALPHA: r_alpha <= i_cfg_data[ALPHA_W-1:0];
                    CFG_DELTA: r_delta <= i_cfg_data[DELTA_W-1:0];
                    CFG_SPEED: r_speed <= i_cfg_data[SPEED_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_ACC) begin
                r_sx    <= sat(nsx);
                r_sy    <= sat(nsy);
                r_count <= r_count + COUNT_W'(1);
            end
            if (r_state == S_DEC && out_free) begin
                o_valid <= 1'b1;
                r_sx    <= '0;
                r_sy    <= '0;
                r_count <= '0;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_item <= i_q_item;
            end
            S_MUL: begin
                r_x    <= r_item.flip ? -DP_W'(prod) : DP_W'(prod);
                r_y    <= '0;
                r_z    <= Z_W'(r_item.bearing) <<< 16;
                r_step <= '0;
            end
            S_ROT, S_VEC: begin
                r_x    <= n_x;
                r_y    <= n_y;
                r_z    <= n_z;
                r_step <= r_step + STEP_W'(1);
            end
            S_SQ: begin
                r_sqx  <= r_sx * r_sx;
                r_sqy  <= r_sy * r_sy;
                r_dc   <= r_delta * r_count;
                r_spec <= (r_sy == '0) || (r_sx == '0);
                if (r_sy == '0) begin
                    r_ang <= (r_sx < 0) ? ANG_W'(32768) : '0;
                end else if (r_sx == '0) begin
                    r_ang <= (r_sy > 0) ? ANG_W'(16384) : -ANG_W'(16384);
                end else begin
                    r_ang <= '0;
                end
                r_x <= (r_sx < 0) ? -vx0 : vx0;
                r_y <= (r_sx < 0) ? -vy0 : vy0;
                r_z <= (r_sx < 0) ? Z_W'(34'h0_8000_0000) : '0;
            end
            S_LIM: begin
                r_len2 <= SQ_W'(r_sqx) + SQ_W'(r_sqy);
                r_lim  <= SQ_W'(r_dc * r_dc);
                r_step <= '0;
            end
            S_DEC: begin
                if (out_free) begin
                    o_led_quadrant <= ang[15:14];
                    if (straight) begin
                        o_drive_mode  <= MODE_STRAIGHT;
                        o_left_speed  <= r_speed;
                        o_right_speed <= r_speed;
                    end else if (ang > 0) begin
                        o_drive_mode  <= MODE_LEFT;
                        o_left_speed  <= r_speed;
                        o_right_speed <= '0;
                    end else begin
                        o_drive_mode  <= MODE_RIGHT;
                        o_left_speed  <= '0;
                        o_right_speed <= r_speed;
                    end
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT) else $error("reading count beyond limit");
    a_mode_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_drive_mode == MODE_LEFT |-> o_right_speed == '0)
        else $error("left turn drives right wheel");
    a_mode_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_drive_mode == MODE_RIGHT |-> o_left_speed == '0)
        else $error("right turn drives left wheel");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DEC && out_free |=> r_count == '0 && o_valid)
        else $error("accumulator not cleared after transaction");
`endif
endmodule
`default_nettype wire

// ----- design/proximity_vector_obstacle_avoid.sv -----
// Proximity vector-sum obstacle avoidance.
// Input channel: i_valid / o_stall carries one proximity reading per transaction
// (magnitude, bearing, last flag). A two-entry queue takes readings while the
// CORDIC engine works, so the sender is stalled only when the queue is full.
// Output channel: o_valid / i_stall carries one wheel command per control step,
// sent after the reading flagged last.
// Each reading goes through the shared CORDIC unit in order: one dequeue, one multiply,
// one micro-rotation per cycle, one accumulate. Readings beyond MAX_READINGS are
// dequeued and dropped. After the last reading the engine forms the length squares,
// runs the vectoring pass (skipped if the sum lies on an axis) and registers the command.
// A stalled command holds in the output register; the engine keeps taking
// readings and waits with the next command until the register is free.
// Reset (synchronous, active low) clears the accumulators, queue and output
// valid, and loads the configuration registers with their defaults.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data, by the
// user only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module proximity_vector_obstacle_avoid #(
    parameter int MAX_READINGS = pvoa_pkg::DEF_MAX_READINGS,
    parameter int CORDIC_STEPS = pvoa_pkg::DEF_CORDIC_STEPS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [pvoa_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [pvoa_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [pvoa_pkg::VALUE_W-1:0]          i_reading_value,
    input  wire logic signed [pvoa_pkg::BEARING_W-1:0] i_reading_bearing,
    input  wire logic                                  i_last_reading,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic [pvoa_pkg::SPEED_W-1:0]               o_left_speed,
    output logic [pvoa_pkg::SPEED_W-1:0]               o_right_speed,
    output logic [1:0]                                 o_led_quadrant,
    output logic [1:0]                                 o_drive_mode
);
    import pvoa_pkg::*;

    logic  q_valid;
    logic  q_pop;
    t_item q_item;

    pvoa_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_reading_value   (i_reading_value),
        .i_reading_bearing (i_reading_bearing),
        .i_last_reading    (i_last_reading),
        .o_q_valid         (q_valid),
        .o_q_item          (q_item),
        .i_q_pop           (q_pop)
    );

    pvoa_back #(
        .MAX_READINGS (MAX_READINGS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_left_speed   (o_left_speed),
        .o_right_speed  (o_right_speed),
        .o_led_quadrant (o_led_quadrant),
        .o_drive_mode   (o_drive_mode)
    );

endmodule
`default_nettype wire

// ----- sim/proximity_vector_obstacle_avoid_checker.sv -----
`timescale 1ns / 1ps
module proximity_vector_obstacle_avoid_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    input  wire logic        i_in_stall,
    input  wire logic [12:0] i_value,
    input  wire logic [15:0] i_bearing,
    input  wire logic        i_last,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [15:0] i_left,
    input  wire logic [15:0] i_right,
    input  wire logic [1:0]  i_quad,
    input  wire logic [1:0]  i_mode,
    output int               o_errors,
    output int               o_pending,
    output int               o_commands
);
    import pvoa_pkg::*;

    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
        logic [1:0]  quad;
        logic [1:0]  mode;
    } t_command;

    t_command cmd_q[$];
    logic [14:0] alpha;
    logic [12:0] delta;
    logic [15:0] speed;
    longint acc_x, acc_y;
    int count;
    int n_err;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_val(int i);
        return longint'(atan_entry(5'(i)));
    endfunction

    task automatic add_reading(input logic [12:0] mag, input logic signed [15:0] brg);
        longint x, y, z, dx, dy, half, full;
        half = 64'sd1 << 30;
        full = 64'sd1 << 31;
        x = longint'(mag) * GAIN_Q16;
        y = 0;
        z = longint'(brg) * 65536;
        if (z > half) begin
            z -= full;
            x = -x;
        end else if (z < -half) begin
            z += full;
            x = -x;
        end
        for (int i = 0; i < DEF_CORDIC_STEPS; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_val(i);
            end else begin
                x += dx; y -= dy; z += atan_val(i);
            end
        end
        acc_x += floor_shr(x + 32768, 16);
        acc_y += floor_shr(y + 32768, 16);
        if (acc_x > 262143) acc_x = 262143;
        if (acc_x < -262144) acc_x = -262144;
        if (acc_y > 262143) acc_y = 262143;
        if (acc_y < -262144) acc_y = -262144;
    endtask

    function automatic int sum_bearing(longint sx, longint sy);
        longint x, y, dx, dy;
        logic [31:0] z;
        logic [15:0] r;
        int a;
        if (sy == 0) return sx < 0 ? 32768 : 0;
        if (sx == 0) return sy > 0 ? 16384 : -16384;
        x = sx * 4096;
        y = sy * 4096;
        z = 0;
        if (x < 0) begin
            x = -x; y = -y; z = 32'h8000_0000;
        end
        for (int i = 0; i < DEF_CORDIC_STEPS; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += atan_entry(5'(i));
            end else begin
                x -= dx; y += dy; z -= atan_entry(5'(i));
            end
        end
        r = 16'((z + 32'h8000) >> 16);
        a = r[15] ? int'(r) - 65536 : int'(r);
        if (a == -32768 && sy > 0) a = 32768;
        return a;
    endfunction

    task automatic take_reading(input logic [12:0] mag, input logic [15:0] brg,
                                input logic last);
        int ang;
        longint len2, lim;
        t_command c;
        if (count < DEF_MAX_READINGS) begin
            add_reading(mag, brg);
            count++;
        end
        if (last) begin
            ang = sum_bearing(acc_x, acc_y);
            len2 = acc_x * acc_x + acc_y * acc_y;
            lim = longint'(delta) * count;
            lim = lim * lim;
            if (ang >= -int'(alpha) && ang <= int'(alpha) && len2 < lim) begin
                c.mode = MODE_STRAIGHT; c.left = speed; c.right = speed;
            end else if (ang > 0) begin
                c.mode = MODE_LEFT; c.left = speed; c.right = 0;
            end else begin
                c.mode = MODE_RIGHT; c.left = 0; c.right = speed;
            end
            c.quad = 2'(16'(ang) >> 14);
            cmd_q.push_back(c);
            acc_x = 0; acc_y = 0; count = 0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            alpha <= ALPHA_RST; delta <= DELTA_RST; speed <= SPEED_RST;
            acc_x = 0; acc_y = 0; count = 0;
            o_errors <= 0;
            o_commands <= 0;
            cmd_q.delete();
        end else begin
            n_err = 0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ALPHA: alpha <= i_cfg_data[14:0];
                    CFG_DELTA: delta <= i_cfg_data[12:0];
                    CFG_SPEED: speed <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_in_stall) take_reading(i_value, i_bearing, i_last);
            if (i_out_valid && !i_out_stall) begin
                o_commands <= o_commands + 1;
                if (cmd_q.size() == 0) begin
                    $error("unexpected command transaction");
                    n_err++;
                end else begin
                    t_command e;
                    e = cmd_q.pop_front();
                    if (e.left !== i_left) begin
                        $error("left_speed exp %0d got %0d", e.left, i_left);
                        n_err++;
                    end
                    if (e.right !== i_right) begin
                        $error("right_speed exp %0d got %0d", e.right, i_right);
                        n_err++;
                    end
                    if (e.quad !== i_quad) begin
                        $error("led_quadrant exp %0d got %0d", e.quad, i_quad);
                        n_err++;
                    end
                    if (e.mode !== i_mode) begin
                        $error("drive_mode exp %0d got %0d", e.mode, i_mode);
                        n_err++;
                    end
                end
            end
            o_errors <= o_errors + n_err;
        end
        o_pending <= cmd_q.size();
    end
endmodule

// ----- sim/proximity_vector_obstacle_avoid_test.sv -----
`timescale 1ns / 1ps
module proximity_vector_obstacle_avoid_test;
    import pvoa_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = 0;
    logic [15:0] cfg_data = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [12:0] value = 0;
    logic signed [15:0] bearing = 0;
    logic        last = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [15:0] left, right;
    logic [1:0]  quad, mode;
    int errors, pending, commands;
    int cycles = 0;
    int sent = 0;
    bit calm = 0;

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    proximity_vector_obstacle_avoid uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .i_valid(in_valid), .o_stall(in_stall),
        .i_reading_value(value), .i_reading_bearing(bearing),
        .i_last_reading(last), .o_valid(out_valid), .i_stall(out_stall),
        .o_left_speed(left), .o_right_speed(right), .o_led_quadrant(quad),
        .o_drive_mode(mode)
    );

    proximity_vector_obstacle_avoid_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_value(value), .i_bearing(bearing), .i_last(last),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_left(left),
        .i_right(right), .i_quad(quad), .i_mode(mode), .o_errors(errors),
        .o_pending(pending), .o_commands(commands)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 1000000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stall bursts
    initial begin
        int n;
        forever begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 16);
                out_stall <= 1;
                repeat (n) @(posedge clk);
                out_stall <= 0;
            end
        end
    end

    task automatic send(input logic [12:0] v, input logic signed [15:0] b, input logic l);
        int n;
        if (!calm && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 16);
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1;
        value <= v;
        bearing <= b;
        last <= l;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] d);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    function automatic logic [12:0] rand_mag();
        case ($urandom_range(0, 7))
            0: return 13'($urandom_range(4097, 8191));
            1: return 0;
            2: return 4096;
            default: return 13'($urandom_range(0, 4096));
        endcase
    endfunction

    task automatic random_step();
        int n;
        logic signed [15:0] center;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 8);
        center = 16'($urandom);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1))
                send(rand_mag(), 16'($urandom), i == n - 1);
            else
                send(rand_mag(), center + 16'($urandom_range(0, 4000)) - 16'd2000,
                     i == n - 1);
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: extremes, axes, empty sum, over-count
        send(0, 0, 1);
        send(4096, 0, 1);
        send(4096, 16'sh7fff, 1);
        send(4096, 16'sh8000, 1);
        send(4096, 16384, 1);
        send(4096, -16384, 1);
        send(8191, 100, 1);
        send(1000, 1000, 0);
        send(1000, -1000, 1);
        for (int i = 0; i < 6; i++) send(8191, 16'sh8000, i == 5);
        drain();
        for (int i = 0; i < 27; i++) send(300, 16'(i * 2400), i == 26);
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_ALPHA, 16'd0); write_reg(CFG_DELTA, 16'd0);
                    write_reg(CFG_SPEED, 16'hffff);
                end
                1: begin
                    write_reg(CFG_ALPHA, 16'h7fff); write_reg(CFG_DELTA, 16'd4096);
                    write_reg(CFG_SPEED, 16'd0);
                end
                2: begin
                    write_reg(CFG_ALPHA, 16'hffff); write_reg(CFG_DELTA, 16'hffff);
                    write_reg(CFG_SPEED, 16'h5555);
                end
                default: begin
                    write_reg(CFG_ALPHA, 16'($urandom_range(0, 32767)));
                    write_reg(CFG_DELTA, 16'($urandom_range(0, 4096)));
                    write_reg(CFG_SPEED, 16'($urandom));
                end
            endcase
            calm = (ph == 5);
            while (sent < 280 * (ph + 1) + 50) random_step();
            drain();
        end
        $display("Run covered %0d readings and %0d wheel commands over 6 settings.",
                 sent, commands);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ----- files.f -----
design/pvoa_pkg.sv
design/pvoa_front.sv
design/pvoa_back.sv
design/proximity_vector_obstacle_avoid.sv
sim/proximity_vector_obstacle_avoid_checker.sv
sim/proximity_vector_obstacle_avoid_test.sv
